FILE: sv/rbs_pkg.sv
// Shared types and constants for the range to block splitter.
// Holds field widths, parameter defaults and the controller/datapath structs.
// No dependencies; compile first.
package rbs_pkg;

    // Field widths.
    localparam int ADDR_W = 38;
    localparam int PART_W = 15;

    // Parameter defaults.
    localparam int PART_BYTES_DEF  = 9728000;
    localparam int BLOCK_BYTES_DEF = 184320;
    localparam int MAX_BLOCKS_DEF  = 64;

    // One result item as held in the output register.
    typedef struct packed {
        logic [PART_W-1:0] part_index;
        logic [ADDR_W-1:0] block_first;
        logic [ADDR_W-1:0] block_last;
        logic              last_of_run;
        logic              truncated;
        logic              bad_range;
    } blk_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_step;
        logic setup;
        logic emit;
        logic emit_bad;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_range;
        logic mul_last;
        logic run_end;
    } sts_t;

endpackage

FILE: sv/rbs_req_if.sv
// Request channel of the range to block splitter: one inclusive byte range.
// Depends on rbs_pkg for the field width.
interface rbs_req_if;
    logic                       valid;
    logic                       ready;
    logic [rbs_pkg::ADDR_W-1:0] range_start;
    logic [rbs_pkg::ADDR_W-1:0] range_end;

    modport source (output valid, output range_start, output range_end, input ready);
    modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

FILE: sv/rbs_blk_if.sv
// Block channel of the range to block splitter: one request block per item.
// Depends on rbs_pkg for the field widths.
interface rbs_blk_if;
    logic                       valid;
    logic                       ready;
    logic [rbs_pkg::PART_W-1:0] part_index;
    logic [rbs_pkg::ADDR_W-1:0] block_first;
    logic [rbs_pkg::ADDR_W-1:0] block_last;
    logic                       last_of_run;
    logic                       truncated;
    logic                       bad_range;

    modport source (output valid, output part_index, output block_first,
                    output block_last, output last_of_run, output truncated,
                    output bad_range, input ready);
    modport sink   (input valid, input part_index, input block_first,
                    input block_last, input last_of_run, input truncated,
                    input bad_range, output ready);
endinterface

FILE: sv/rbs_ctrl.sv
// Controller of the range to block splitter: sequences multiply, setup and emit.
// Depends on rbs_pkg for the command and status structs.
module rbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  rbs_pkg::sts_t sts,
    output rbs_pkg::cmd_t cmd
);
    import rbs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // The output register can take a new item when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.bad_range ? ST_BAD : ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.run_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD:
            begin
                if (slot_free)
                begin
                    cmd.emit_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows emits and downstream takes.
    always_comb
    begin
        if (cmd.emit || cmd.emit_bad)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/rbs_datapath.sv
// Datapath of the range to block splitter: part index by reciprocal multiply,
// block generator and the output register. Depends on rbs_pkg.
module rbs_datapath #(
    parameter int PART_BYTES  = rbs_pkg::PART_BYTES_DEF,
    parameter int BLOCK_BYTES = rbs_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS  = rbs_pkg::MAX_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rbs_pkg::ADDR_W-1:0] range_start,
    input  logic [rbs_pkg::ADDR_W-1:0] range_end,
    input  rbs_pkg::cmd_t              cmd,
    output rbs_pkg::sts_t              sts,
    output rbs_pkg::blk_t              blk
);
    import rbs_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = ADDR_W + 1;
    // The reciprocal is scaled by 2^RK so that the quotient is exact for every
    // offset of ADDR_W bits; it needs at most ADDR_W + 2 bits.
    localparam int RK = ADDR_W + $clog2(PART_BYTES);
    localparam int MW = ADDR_W + 2;
    localparam int HW = (ADDR_W + 1) / 2;
    localparam int PW = HW + MW;
    localparam int AW = ADDR_W + MW;
    localparam int QW = AW - RK;
    localparam logic [63:0]   RECIP_FULL = ((64'd1 << RK) + 64'(PART_BYTES) - 64'd1)
                                           / 64'(PART_BYTES);
    localparam logic [MW-1:0] RECIP    = MW'(RECIP_FULL);
    localparam logic [EW-1:0] PART_EXT = EW'(PART_BYTES);
    localparam logic [EW-1:0] PART_M1  = EW'(PART_BYTES - 1);
    localparam logic [EW-1:0] BLOCK_M1 = EW'(BLOCK_BYTES - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_BLOCKS - 1);

    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic [ADDR_W-1:0] end_reg;
    logic [AW-1:0]     acc_reg, acc_next;
    logic              mul_cnt_reg;
    logic [PART_W-1:0] part_reg, part_next;
    logic [EW-1:0]     part_last_reg, part_last_next;
    logic [CW-1:0]     cnt_reg;
    blk_t              blk_reg;

    logic [HW-1:0]     mul_half;
    logic [PW-1:0]     half_prod;
    logic [QW-1:0]     quo;
    logic [EW-1:0]     stop_blk, stop_part, stop_fin, end_ext;
    logic              done, trunc;

    // Offset times the scaled reciprocal, one half of the offset per step:
    // the low half first, then the high half shifted into place.
    assign mul_half  = mul_cnt_reg ? HW'(offset_reg[ADDR_W-1:HW]) : offset_reg[HW-1:0];
    assign half_prod = PW'(mul_half) * PW'(RECIP);
    assign quo       = acc_reg[AW-1:RK];

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = '0;
        end
        else if (cmd.mul_step)
        begin
            acc_next = acc_reg + (mul_cnt_reg ? (AW'(half_prod) << HW) : AW'(half_prod));
        end
    end

    // Block end: nearest of block size, part end and range end.
    assign end_ext   = {1'b0, end_reg};
    assign stop_blk  = {1'b0, offset_reg} + BLOCK_M1;
    assign stop_part = (part_last_reg < stop_blk) ? part_last_reg : stop_blk;
    assign stop_fin  = (end_ext < stop_part) ? end_ext : stop_part;
    assign done      = (stop_fin == end_ext);
    assign trunc     = !done && (cnt_reg == CNT_LAST);

    assign sts.bad_range = (range_start > range_end);
    assign sts.mul_last  = mul_cnt_reg;
    assign sts.run_end   = done || trunc;

    // Walk state: offset, part index and the last byte of the current part.
    always_comb
    begin
        offset_next    = offset_reg;
        part_next      = part_reg;
        part_last_next = part_last_reg;
        if (cmd.load)
        begin
            offset_next = range_start;
        end
        else if (cmd.setup)
        begin
            part_next      = quo[PART_W-1:0];
            part_last_next = EW'(quo) * PART_EXT + PART_M1;
        end
        else if (cmd.emit)
        begin
            offset_next = stop_fin[ADDR_W-1:0] + 1'b1;
            if (stop_fin == part_last_reg)
            begin
                part_next      = part_reg + 1'b1;
                part_last_next = part_last_reg + PART_EXT;
            end
        end
    end

    // Multiply step flag and block counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                mul_cnt_reg <= 1'b0;
            end
            else if (cmd.mul_step)
            begin
                mul_cnt_reg <= 1'b1;
            end
            if (cmd.setup)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        offset_reg    <= offset_next;
        acc_reg       <= acc_next;
        part_reg      <= part_next;
        part_last_reg <= part_last_next;
        if (cmd.load)
        begin
            end_reg <= range_end;
        end
        if (cmd.emit)
        begin
            blk_reg.part_index  <= part_reg;
            blk_reg.block_first <= offset_reg;
            blk_reg.block_last  <= stop_fin[ADDR_W-1:0];
            blk_reg.last_of_run <= done || trunc;
            blk_reg.truncated   <= trunc;
            blk_reg.bad_range   <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            blk_reg.part_index  <= '0;
            blk_reg.block_first <= '0;
            blk_reg.block_last  <= '0;
            blk_reg.last_of_run <= 1'b1;
            blk_reg.truncated   <= 1'b0;
            blk_reg.bad_range   <= 1'b1;
        end
    end

    assign blk = blk_reg;

endmodule

FILE: sv/range_to_block_splitter.sv
// Range to block splitter: an inclusive byte range in, a run of request blocks out.
// The req channel takes one range as an item; the blk channel gives one block
// per item, each ending at the nearest of block size, part end and range end.
// A range is taken only while the block is idle. For a good range the part
// index of the start offset is found by multiplying with the reciprocal of the
// part size, one half of the offset per cycle, then a setup step, then one
// block per cycle while blk is not stalled. A run of at most MAX_BLOCKS blocks
// keeps req closed until its last block is loaded into the output register.
// An inverted range gives a single error item, loaded into the output register
// once it is free, after which req opens again.
// The last block of a run carries last_of_run; a run cut at MAX_BLOCKS blocks
// also carries truncated. A new range may be taken while the final block
// still waits in the output register.
// A stalled blk channel holds the current item and pauses block generation.
// Reset returns the controller to idle and empties the output register.
// Depends on rbs_pkg, rbs_req_if, rbs_blk_if, rbs_ctrl and rbs_datapath.
module range_to_block_splitter #(
    parameter int PART_BYTES  = rbs_pkg::PART_BYTES_DEF,
    parameter int BLOCK_BYTES = rbs_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS  = rbs_pkg::MAX_BLOCKS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    rbs_req_if.sink  req,
    rbs_blk_if.source blk
);
    import rbs_pkg::*;

    cmd_t cmd;
    sts_t sts;
    blk_t blk_q;

    // Controller.
    rbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (blk.valid),
        .out_ready (blk.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    rbs_datapath #(
        .PART_BYTES  (PART_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_start (req.range_start),
        .range_end   (req.range_end),
        .cmd         (cmd),
        .sts         (sts),
        .blk         (blk_q)
    );

    // Output payload.
    assign blk.part_index  = blk_q.part_index;
    assign blk.block_first = blk_q.block_first;
    assign blk.block_last  = blk_q.block_last;
    assign blk.last_of_run = blk_q.last_of_run;
    assign blk.truncated   = blk_q.truncated;
    assign blk.bad_range   = blk_q.bad_range;

`ifndef SYNTHESIS
    // A block never ends before it starts.
    a_block_order: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && !blk.bad_range |-> blk.block_first <= blk.block_last)
        else $error("block ends before it starts");

    // An error item is alone in its run and carries zero block fields.
    a_bad_item: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && blk.bad_range |-> blk.last_of_run && !blk.truncated
            && blk.block_first == '0 && blk.block_last == '0)
        else $error("malformed error item");

    // Truncation is only flagged on the final block of a run.
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && blk.truncated |-> blk.last_of_run)
        else $error("truncated flag on a non-final block");

    // A taken range keeps the request channel closed on the next cycle.
    a_one_range: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request channel open while a range is in work");
`endif

endmodule

FILE: tb/sv/range_to_block_splitter_tb.sv
// Self-checking testbench for range_to_block_splitter: directed ranges, then random ones.
// Every accepted range is split into blocks by a local model and compared item by item.
// Depends on rbs_pkg, rbs_req_if, rbs_blk_if and the block itself.
module range_to_block_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbs_pkg::*;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [63:0]       wide_t;

    // Directed stimulus row: a range and, where obvious, its single expected block.
    typedef struct {
        addr_t first;
        addr_t last;
        bit    typed;
        blk_t  want;
    } range_row_t;

    localparam wide_t PART_SIZE   = PART_BYTES_DEF;
    localparam wide_t BLOCK_SIZE  = BLOCK_BYTES_DEF;
    localparam int    RUN_LIMIT   = MAX_BLOCKS_DEF;
    localparam addr_t TOP_ADDR    = '1;
    localparam int    NUM_ROWS    = 17;
    localparam int    RAND_PER_PHASE = 28;
    localparam int    CYCLE_LIMIT = 500000;
    localparam int    DRAIN_CYCLES = 60;
    localparam int    HOLD_AT_BLOCK = 200;
    localparam int    HOLD_CYCLES  = 400;

    // Known single-block outcomes.
    localparam blk_t BAD_RANGE_BLK = '{15'd0, 38'd0, 38'd0, 1'b1, 1'b0, 1'b1};
    localparam blk_t ZERO_BYTE_BLK = '{15'd0, 38'd0, 38'd0, 1'b1, 1'b0, 1'b0};
    localparam blk_t TOP_BYTE_BLK  = '{15'd28256, '1, '1, 1'b1, 1'b0, 1'b0};

    logic clk;
    logic rst_n;

    rbs_req_if req_ch ();
    rbs_blk_if blk_ch ();

    range_to_block_splitter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .blk   (blk_ch)
    );

    blk_t       blocks_due[$];
    range_row_t dir_rows[NUM_ROWS];
    int         error_count = 0;
    int         blocks_seen = 0;
    int         cycle_count = 0;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Split one range into its expected blocks and queue them in order.
    function automatic void split_range(input addr_t s, input addr_t e);
        wide_t offset;
        wide_t part;
        wide_t part_top;
        wide_t stop;
        wide_t range_last;
        blk_t  b;
        bit    done;
        int    n;
        range_last = e;
        if (s > e)
        begin
            blocks_due.insert(blocks_due.size(), BAD_RANGE_BLK);
            return;
        end
        offset = s;
        done = 1'b0;
        for (n = 1; n <= RUN_LIMIT && !done; n++)
        begin
            part = offset / PART_SIZE;
            part_top = (part + 1) * PART_SIZE - 1;
            stop = offset + BLOCK_SIZE - 1;
            if (part_top < stop)
                stop = part_top;
            if (range_last < stop)
                stop = range_last;
            done = (stop == range_last);
            b = '0;
            b.part_index  = part[PART_W-1:0];
            b.block_first = offset[ADDR_W-1:0];
            b.block_last  = stop[ADDR_W-1:0];
            b.last_of_run = done || (n == RUN_LIMIT);
            b.truncated   = !done && (n == RUN_LIMIT);
            blocks_due.insert(blocks_due.size(), b);
            offset = stop + 1;
        end
    endfunction

    function automatic addr_t rand_addr();
        wide_t r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    // Offer one range after a random gap and queue its blocks once it is taken.
    task automatic offer_range(input addr_t s, input addr_t e, input bit typed,
                               input blk_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.range_start <= s;
        req_ch.range_end   <= e;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (typed)
            blocks_due.insert(blocks_due.size(), want);
        else
            split_range(s, e);
    endtask

    // Compare one received block with the oldest expected one.
    task automatic check_block(input blk_t got);
        blk_t want;
        if (blocks_due.size() == 0)
        begin
            $error("unexpected block: first %0d last %0d", got.block_first, got.block_last);
            error_count++;
            return;
        end
        want = blocks_due.pop_front();
        if (got.part_index !== want.part_index)
        begin
            $error("part_index: expected %0d, got %0d", want.part_index, got.part_index);
            error_count++;
        end
        if (got.block_first !== want.block_first)
        begin
            $error("block_first: expected %0d, got %0d", want.block_first, got.block_first);
            error_count++;
        end
        if (got.block_last !== want.block_last)
        begin
            $error("block_last: expected %0d, got %0d", want.block_last, got.block_last);
            error_count++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            error_count++;
        end
        if (got.truncated !== want.truncated)
        begin
            $error("truncated: expected %0b, got %0b", want.truncated, got.truncated);
            error_count++;
        end
        if (got.bad_range !== want.bad_range)
        begin
            $error("bad_range: expected %0b, got %0b", want.bad_range, got.bad_range);
            error_count++;
        end
    endtask

    // Block receiver: checks each accepted item, stalls at random, and once
    // holds off for a long stretch so that the splitter backs up.
    initial
    begin
        blk_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (blk_ch.valid && blk_ch.ready)
            begin
                check_block({blk_ch.part_index, blk_ch.block_first, blk_ch.block_last,
                             blk_ch.last_of_run, blk_ch.truncated, blk_ch.bad_range});
                blocks_seen++;
                if (!hold_done && blocks_seen == HOLD_AT_BLOCK)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                blk_ch.ready <= 1'b0;
            end
            else
                blk_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
        end
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("range_to_block_splitter verification failed");
            $finish;
        end
    end

    // Reset, directed table, random phases, drain and verdict.
    initial
    begin
        wide_t s;
        wide_t e;
        wide_t span;
        wide_t k;
        int    kind;
        int    phase;
        int    i;

        send_idle_pct = 35;
        recv_idle_pct = 59;
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.range_start <= '0;
        req_ch.range_end   <= '0;

        // Extremes, inverted ranges, block and part edges, runs around the cut-off.
        dir_rows[0]  = '{38'd0, 38'd0, 1'b1, ZERO_BYTE_BLK};
        dir_rows[1]  = '{TOP_ADDR, TOP_ADDR, 1'b1, TOP_BYTE_BLK};
        dir_rows[2]  = '{38'd1, 38'd0, 1'b1, BAD_RANGE_BLK};
        dir_rows[3]  = '{TOP_ADDR, 38'd0, 1'b1, BAD_RANGE_BLK};
        dir_rows[4]  = '{TOP_ADDR, TOP_ADDR - 1, 1'b1, BAD_RANGE_BLK};
        dir_rows[5]  = '{38'd0, TOP_ADDR, 1'b0, '0};
        dir_rows[6]  = '{38'd0, 38'd184319, 1'b0, '0};
        dir_rows[7]  = '{38'd0, 38'd184320, 1'b0, '0};
        dir_rows[8]  = '{38'd9727999, 38'd9728000, 1'b0, '0};
        dir_rows[9]  = '{38'd0, 38'd11755519, 1'b0, '0};
        dir_rows[10] = '{38'd0, 38'd11755520, 1'b0, '0};
        dir_rows[11] = '{38'd0, 38'd11571199, 1'b0, '0};
        dir_rows[12] = '{38'd48639900, 38'd49140000, 1'b0, '0};
        dir_rows[13] = '{TOP_ADDR - 38'd552960, TOP_ADDR, 1'b0, '0};
        dir_rows[14] = '{38'h2A_AAAA_AAAA, 38'h2A_AAB9_EAEA, 1'b0, '0};
        dir_rows[15] = '{38'h15_5555_5555, TOP_ADDR, 1'b0, '0};
        dir_rows[16] = '{38'd0, 38'd9727999, 1'b0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
            offer_range(dir_rows[i].first, dir_rows[i].last, dir_rows[i].typed,
                        dir_rows[i].want);

        // Random ranges under three idling patterns.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 35 : 0;
            for (i = 0; i < RAND_PER_PHASE; i++)
            begin
                kind = $urandom_range(99);
                s = rand_addr();
                if (kind < 10)
                begin
                    // Inverted range.
                    e = rand_addr();
                    if (e == TOP_ADDR)
                        e = e - 1;
                    s = e + 1 + ({$urandom(), $urandom()} % (TOP_ADDR - e));
                end
                else
                begin
                    if (kind < 35)
                        span = $urandom_range(2000);
                    else if (kind < 60)
                        span = $urandom_range(20 * BLOCK_BYTES_DEF);
                    else if (kind < 75)
                        span = 55 * BLOCK_SIZE + $urandom_range(15 * BLOCK_BYTES_DEF);
                    else if (kind < 88)
                    begin
                        // Start just below a part edge.
                        k = $urandom_range(28256, 1);
                        s = k * PART_SIZE - $urandom_range(300);
                        span = $urandom_range(3 * BLOCK_BYTES_DEF);
                    end
                    else
                        span = {$urandom(), $urandom()} % (TOP_ADDR - s + 1);
                    if (span > TOP_ADDR - s)
                        e = TOP_ADDR;
                    else
                        e = s + span;
                end
                offer_range(s[ADDR_W-1:0], e[ADDR_W-1:0], 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        // Drain, then watch a little longer for stray items.
        while (blocks_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("range_to_block_splitter verification clean");
        else
            $display("range_to_block_splitter verification failed");
        $finish;
    end

endmodule
